// ===== rtl/pfa_pkg.sv =====
// Shared constants, codes and control types of the physical frame allocator.
package pfa_pkg;

   localparam int ADDRESS_BITS     = 48;
   localparam int REGION_SLOTS     = 256;
   localparam int KERNEL_SLOTS     = 256;
   localparam int FREE_QUEUE_DEPTH = 1024;

   localparam int OFFSET_BITS = 12;
   localparam int FRAME_BITS  = ADDRESS_BITS - OFFSET_BITS;
   localparam int CAND_BITS   = FRAME_BITS + 1;
   localparam int REGION_IDX  = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
   localparam int KERNEL_IDX  = (KERNEL_SLOTS > 1) ? $clog2(KERNEL_SLOTS) : 1;
   localparam int SLOT_IDX    = (REGION_IDX > KERNEL_IDX) ? REGION_IDX : KERNEL_IDX;
   localparam int REGION_CNT  = $clog2(REGION_SLOTS + 1);
   localparam int KERNEL_CNT  = $clog2(KERNEL_SLOTS + 1);
   localparam int QUEUE_IDX   = $clog2(FREE_QUEUE_DEPTH);
   localparam int QUEUE_CNT   = $clog2(FREE_QUEUE_DEPTH + 1);
   localparam int GUARD_BITS  = $clog2(KERNEL_SLOTS + 2);
   localparam logic [GUARD_BITS-1:0] GUARD_LAST = GUARD_BITS'(KERNEL_SLOTS + 1);

   localparam logic [1:0] CMD_ADD_USABLE = 2'd0;
   localparam logic [1:0] CMD_ADD_KERNEL = 2'd1;
   localparam logic [1:0] CMD_ALLOCATE   = 2'd2;
   localparam logic [1:0] CMD_FREE       = 2'd3;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_EMPTY      = 2'd1;
   localparam logic [1:0] STATUS_MISALIGNED = 2'd2;
   localparam logic [1:0] STATUS_FULL       = 2'd3;

   typedef struct packed {
      logic latch_req;
      logic decode;
      logic u_start;
      logic u_read;
      logic u_eval;
      logic u_done;
      logic k_read;
      logic k_eval;
      logic got;
      logic fail_scan;
      logic pop_read;
      logic pop_data;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] command;
      logic       exhausted;
      logic       at_frame_max;
      logic       usable_empty;
      logic       u_last;
      logic       found;
      logic       kernel_empty;
      logic       k_last;
      logic       k_hit;
      logic       guard_last;
      logic       queue_empty;
      logic       rsp_free;
   } dp_status_type;

endpackage

// ===== rtl/pfa_ctrl.sv =====
// Controller state machine that sequences requests and the region scan.
module pfa_ctrl import pfa_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type st,
   output dp_cmd_type    cmd
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DECODE  = 4'd1;
   localparam logic [3:0] S_USTART  = 4'd2;
   localparam logic [3:0] S_UREAD   = 4'd3;
   localparam logic [3:0] S_UEVAL   = 4'd4;
   localparam logic [3:0] S_UDONE   = 4'd5;
   localparam logic [3:0] S_KREAD   = 4'd6;
   localparam logic [3:0] S_KEVAL   = 4'd7;
   localparam logic [3:0] S_GOT     = 4'd8;
   localparam logic [3:0] S_FAIL    = 4'd9;
   localparam logic [3:0] S_POP     = 4'd10;
   localparam logic [3:0] S_POPDATA = 4'd11;
   localparam logic [3:0] S_FINISH  = 4'd12;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            if (st.command != CMD_ALLOCATE) begin
               state_in = S_FINISH;
            end else if (st.exhausted) begin
               state_in = S_POP;
            end else if (st.at_frame_max) begin
               state_in = S_FAIL;
            end else begin
               state_in = S_USTART;
            end
         end
         S_USTART: begin
            cmd.u_start = 1'b1;
            state_in    = st.usable_empty ? S_FAIL : S_UREAD;
         end
         S_UREAD: begin
            cmd.u_read = 1'b1;
            state_in   = S_UEVAL;
         end
         S_UEVAL: begin
            cmd.u_eval = 1'b1;
            state_in   = st.u_last ? S_UDONE : S_UREAD;
         end
         S_UDONE: begin
            cmd.u_done = 1'b1;
            if (!st.found) begin
               state_in = S_FAIL;
            end else if (st.kernel_empty) begin
               state_in = S_GOT;
            end else begin
               state_in = S_KREAD;
            end
         end
         S_KREAD: begin
            cmd.k_read = 1'b1;
            state_in   = S_KEVAL;
         end
         S_KEVAL: begin
            cmd.k_eval = 1'b1;
            if (st.k_hit) begin
               state_in = st.guard_last ? S_FAIL : S_USTART;
            end else begin
               state_in = st.k_last ? S_GOT : S_KREAD;
            end
         end
         S_GOT: begin
            cmd.got  = 1'b1;
            state_in = S_FINISH;
         end
         S_FAIL: begin
            cmd.fail_scan = 1'b1;
            state_in      = S_POP;
         end
         S_POP: begin
            cmd.pop_read = 1'b1;
            state_in     = st.queue_empty ? S_FINISH : S_POPDATA;
         end
         S_POPDATA: begin
            cmd.pop_data = 1'b1;
            state_in     = S_FINISH;
         end
         S_FINISH: begin
            if (st.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/pfa_dp.sv =====
// Datapath holding the region tables, the freed-frame queue and the scan registers.
module pfa_dp import pfa_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  dp_cmd_type              cmd,
   output dp_status_type           st,
   input  logic [1:0]              req_command,
   input  logic [ADDRESS_BITS-1:0] req_region_start,
   input  logic [ADDRESS_BITS-1:0] req_region_end,
   input  logic [ADDRESS_BITS-1:0] req_free_address,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [ADDRESS_BITS-1:0] rsp_frame_address,
   output logic [1:0]              rsp_status
);

   logic [2*ADDRESS_BITS-1:0] usable_mem [REGION_SLOTS];
   logic [2*ADDRESS_BITS-1:0] kernel_mem [KERNEL_SLOTS];
   logic [FRAME_BITS-1:0]     queue_mem  [FREE_QUEUE_DEPTH];

   logic [2*ADDRESS_BITS-1:0] u_rd_ff;
   logic [2*ADDRESS_BITS-1:0] k_rd_ff;
   logic [FRAME_BITS-1:0]     q_rd_ff;

   logic [1:0]              command_ff;
   logic [ADDRESS_BITS-1:0] start_ff;
   logic [ADDRESS_BITS-1:0] end_ff;
   logic [ADDRESS_BITS-1:0] free_ff;

   logic [REGION_CNT-1:0]   usable_count_ff;
   logic [KERNEL_CNT-1:0]   kernel_count_ff;
   logic [FRAME_BITS-1:0]   cursor_ff;
   logic                    exhausted_ff;
   logic [QUEUE_IDX-1:0]    rptr_ff;
   logic [QUEUE_IDX-1:0]    wptr_ff;
   logic [QUEUE_CNT-1:0]    qcount_ff;
   logic                    rsp_valid_ff;

   logic [CAND_BITS-1:0]    cand_ff;
   logic [CAND_BITS-1:0]    best_ff;
   logic                    found_ff;
   logic [SLOT_IDX-1:0]     idx_ff;
   logic [GUARD_BITS-1:0]   guard_ff;
   logic [ADDRESS_BITS-1:0] res_addr_ff;
   logic [1:0]              res_status_ff;
   logic [ADDRESS_BITS-1:0] rsp_addr_ff;
   logic [1:0]              rsp_status_ff;

   logic [ADDRESS_BITS-1:0] u_start;
   logic [ADDRESS_BITS-1:0] u_end;
   logic [ADDRESS_BITS-1:0] k_start;
   logic [ADDRESS_BITS-1:0] k_end;
   logic [CAND_BITS-1:0]    sf_ceil;
   logic [CAND_BITS-1:0]    sf;
   logic [CAND_BITS-1:0]    ef;
   logic                    u_take;
   logic [ADDRESS_BITS-1:0] frame_lo;
   logic [ADDRESS_BITS-1:0] frame_hi;
   logic [CAND_BITS-1:0]    k_skip;
   logic                    usable_full;
   logic                    kernel_full;
   logic                    queue_full;
   logic                    misaligned;
   logic [QUEUE_IDX-1:0]    rptr_in;
   logic [QUEUE_IDX-1:0]    wptr_in;

   assign u_start = u_rd_ff[2*ADDRESS_BITS-1:ADDRESS_BITS];
   assign u_end   = u_rd_ff[ADDRESS_BITS-1:0];
   assign k_start = k_rd_ff[2*ADDRESS_BITS-1:ADDRESS_BITS];
   assign k_end   = k_rd_ff[ADDRESS_BITS-1:0];

   assign sf_ceil = {1'b0, u_start[ADDRESS_BITS-1:OFFSET_BITS]}
                  + CAND_BITS'(|u_start[OFFSET_BITS-1:0]);
   assign sf      = (sf_ceil < cand_ff) ? cand_ff : sf_ceil;
   assign ef      = {1'b0, u_end[ADDRESS_BITS-1:OFFSET_BITS]};
   assign u_take  = (sf < ef) && (!found_ff || sf < best_ff);

   assign frame_lo = {best_ff[FRAME_BITS-1:0], {OFFSET_BITS{1'b0}}};
   assign frame_hi = {best_ff[FRAME_BITS-1:0], {OFFSET_BITS{1'b1}}};
   assign k_skip   = {1'b0, k_end[ADDRESS_BITS-1:OFFSET_BITS]}
                   + CAND_BITS'(|k_end[OFFSET_BITS-1:0]);

   assign usable_full = (usable_count_ff >= REGION_CNT'(REGION_SLOTS));
   assign kernel_full = (kernel_count_ff >= KERNEL_CNT'(KERNEL_SLOTS));
   assign queue_full  = (qcount_ff >= QUEUE_CNT'(FREE_QUEUE_DEPTH));
   assign misaligned  = |free_ff[OFFSET_BITS-1:0];

   assign rptr_in = (rptr_ff == QUEUE_IDX'(FREE_QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
   assign wptr_in = (wptr_ff == QUEUE_IDX'(FREE_QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;

   always_comb begin
      st              = '0;
      st.command      = command_ff;
      st.exhausted    = exhausted_ff;
      st.at_frame_max = &cursor_ff;
      st.usable_empty = (usable_count_ff == '0);
      st.u_last       = (REGION_CNT'(idx_ff[REGION_IDX-1:0]) + 1'b1) == usable_count_ff;
      st.found        = found_ff;
      st.kernel_empty = (kernel_count_ff == '0);
      st.k_last       = (KERNEL_CNT'(idx_ff[KERNEL_IDX-1:0]) + 1'b1) == kernel_count_ff;
      st.k_hit        = (frame_hi >= k_start) && (frame_lo < k_end);
      st.guard_last   = (guard_ff == GUARD_LAST);
      st.queue_empty  = (qcount_ff == '0);
      st.rsp_free     = !rsp_valid_ff || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (cmd.decode && command_ff == CMD_ADD_USABLE && !usable_full) begin
         usable_mem[usable_count_ff[REGION_IDX-1:0]] <= {start_ff, end_ff};
      end
      if (cmd.u_read) begin
         u_rd_ff <= usable_mem[idx_ff[REGION_IDX-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decode && command_ff == CMD_ADD_KERNEL && !kernel_full) begin
         kernel_mem[kernel_count_ff[KERNEL_IDX-1:0]] <= {start_ff, end_ff};
      end
      if (cmd.k_read) begin
         k_rd_ff <= kernel_mem[idx_ff[KERNEL_IDX-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decode && command_ff == CMD_FREE && !misaligned && !queue_full) begin
         queue_mem[wptr_ff] <= free_ff[ADDRESS_BITS-1:OFFSET_BITS];
      end
      if (cmd.pop_read) begin
         q_rd_ff <= queue_mem[rptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         usable_count_ff <= '0;
         kernel_count_ff <= '0;
         cursor_ff       <= '0;
         exhausted_ff    <= 1'b0;
         rptr_ff         <= '0;
         wptr_ff         <= '0;
         qcount_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (cmd.decode) begin
            unique case (command_ff)
               CMD_ADD_USABLE: begin
                  if (!usable_full) begin
                     usable_count_ff <= usable_count_ff + 1'b1;
                  end
               end
               CMD_ADD_KERNEL: begin
                  if (!kernel_full) begin
                     kernel_count_ff <= kernel_count_ff + 1'b1;
                  end
               end
               CMD_FREE: begin
                  if (!misaligned && !queue_full) begin
                     wptr_ff   <= wptr_in;
                     qcount_ff <= qcount_ff + 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         if (cmd.got) begin
            cursor_ff <= best_ff[FRAME_BITS-1:0];
         end
         if (cmd.fail_scan) begin
            exhausted_ff <= 1'b1;
         end
         if (cmd.pop_data) begin
            rptr_ff   <= rptr_in;
            qcount_ff <= qcount_ff - 1'b1;
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         command_ff <= req_command;
         start_ff   <= req_region_start;
         end_ff     <= req_region_end;
         free_ff    <= req_free_address;
      end
      if (cmd.decode) begin
         res_addr_ff <= '0;
         cand_ff     <= {1'b0, cursor_ff} + 1'b1;
         guard_ff    <= '0;
         unique case (command_ff)
            CMD_ADD_USABLE: res_status_ff <= usable_full ? STATUS_FULL : STATUS_OK;
            CMD_ADD_KERNEL: res_status_ff <= kernel_full ? STATUS_FULL : STATUS_OK;
            CMD_FREE: begin
               if (misaligned) begin
                  res_status_ff <= STATUS_MISALIGNED;
               end else begin
                  res_status_ff <= queue_full ? STATUS_FULL : STATUS_OK;
               end
            end
            default: res_status_ff <= STATUS_OK;
         endcase
      end
      if (cmd.u_start) begin
         idx_ff   <= '0;
         found_ff <= 1'b0;
      end
      if (cmd.u_eval) begin
         idx_ff <= idx_ff + 1'b1;
         if (u_take) begin
            best_ff  <= sf;
            found_ff <= 1'b1;
         end
      end
      if (cmd.u_done) begin
         idx_ff <= '0;
      end
      if (cmd.k_eval) begin
         idx_ff <= idx_ff + 1'b1;
         if (st.k_hit) begin
            cand_ff  <= k_skip;
            guard_ff <= guard_ff + 1'b1;
         end
      end
      if (cmd.got) begin
         res_addr_ff <= frame_lo;
      end
      if (cmd.pop_read && st.queue_empty) begin
         res_status_ff <= STATUS_EMPTY;
      end
      if (cmd.pop_data) begin
         res_addr_ff <= {q_rd_ff, {OFFSET_BITS{1'b0}}};
      end
      if (cmd.finish) begin
         rsp_addr_ff   <= res_addr_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_address = rsp_addr_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

// ===== rtl/physical_frame_allocator.sv =====
// Top level of the physical frame allocator: controller plus datapath.
// The request channel carries a command with region bounds or a freed address.
// Commands add a usable region, add a kernel section, allocate a frame or free one.
// Each request gives exactly one response with a frame address and a status.
// A request is taken only while the controller is idle; one is worked at a time.
// Adds and frees pass from acceptance through the decode and finish states to the response.
// An allocation from the scan reads and evaluates every usable region and each
// kernel section checked, for every candidate frame tried.
// The scan reads one table entry at a time, a read state before each evaluate state.
// An allocation served from the freed-frame queue goes through the pop and pop-data states.
// The response is held in an output register until taken; while it is stalled a
// new request may still be accepted, but its response waits for the register.
// Reset empties both tables and the queue and restarts the scan at frame 1.
module physical_frame_allocator import pfa_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_command,
   input  logic [ADDRESS_BITS-1:0] req_region_start,
   input  logic [ADDRESS_BITS-1:0] req_region_end,
   input  logic [ADDRESS_BITS-1:0] req_free_address,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [ADDRESS_BITS-1:0] rsp_frame_address,
   output logic [1:0]              rsp_status
);

   dp_cmd_type    cmd;
   dp_status_type st;

   pfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   pfa_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .st                (st),
      .req_command       (req_command),
      .req_region_start  (req_region_start),
      .req_region_end    (req_region_end),
      .req_free_address  (req_free_address),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_address (rsp_frame_address),
      .rsp_status        (rsp_status)
   );

endmodule

// ===== verif/pfa_checker.sv =====
// Checker for the physical frame allocator: tracks requests, predicts responses and compares.
`timescale 1ns / 100ps
module pfa_checker import pfa_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic [1:0]              req_command,
   input  logic [ADDRESS_BITS-1:0] req_region_start,
   input  logic [ADDRESS_BITS-1:0] req_region_end,
   input  logic [ADDRESS_BITS-1:0] req_free_address,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic [ADDRESS_BITS-1:0] rsp_frame_address,
   input  logic [1:0]              rsp_status,
   output int                      fail_count,
   output int                      pending
);

   localparam logic [63:0] LAST_FRAME = (64'd1 << FRAME_BITS) - 1;

   typedef struct packed {
      logic [ADDRESS_BITS-1:0] frame_address;
      logic [1:0]              status;
   } grant_type;

   grant_type   grants[$];
   logic [63:0] region_lo[0:REGION_SLOTS-1];
   logic [63:0] region_hi[0:REGION_SLOTS-1];
   int          region_cnt;
   logic [63:0] kern_lo[0:KERNEL_SLOTS-1];
   logic [63:0] kern_hi[0:KERNEL_SLOTS-1];
   int          kern_cnt;
   logic [63:0] cursor;
   bit          exhausted;
   logic [63:0] returned_frames[$];

   function automatic logic [63:0] round_up_frame(input logic [63:0] a);
      return (a >> OFFSET_BITS) + ((a[OFFSET_BITS-1:0] != 0) ? 64'd1 : 64'd0);
   endfunction

   function automatic bit lowest_usable(input logic [63:0] c, output logic [63:0] fr);
      bit          found;
      logic [63:0] sf;
      logic [63:0] ef;
      found = 0;
      fr = 0;
      for (int i = 0; i < region_cnt; i++) begin
         sf = round_up_frame(region_lo[i]);
         ef = region_hi[i] >> OFFSET_BITS;
         if (sf < c) sf = c;
         if (sf < ef && (!found || sf < fr)) begin
            fr = sf;
            found = 1;
         end
      end
      return found;
   endfunction

   function automatic bit kernel_hit(input logic [63:0] f, output logic [63:0] past);
      logic [63:0] lo;
      logic [63:0] hi;
      lo = f << OFFSET_BITS;
      hi = lo + 64'd4095;
      past = 0;
      for (int j = 0; j < kern_cnt; j++) begin
         if (hi >= kern_lo[j] && lo < kern_hi[j]) begin
            past = round_up_frame(kern_hi[j]);
            return 1;
         end
      end
      return 0;
   endfunction

   function automatic bit next_scan_frame(output logic [63:0] fr);
      logic [63:0] c;
      logic [63:0] f;
      logic [63:0] skip;
      fr = 0;
      if (cursor >= LAST_FRAME) return 0;
      c = cursor + 1;
      for (int g = 0; g <= KERNEL_SLOTS + 1; g++) begin
         if (!lowest_usable(c, f)) return 0;
         if (!kernel_hit(f, skip)) begin
            fr = f;
            return 1;
         end
         c = skip;
      end
      return 0;
   endfunction

   function automatic grant_type serve_request(input logic [1:0] cmd, input logic [63:0] rs,
                                               input logic [63:0] re, input logic [63:0] fa);
      grant_type   g;
      logic [63:0] f;
      bit          got;
      g.frame_address = '0;
      g.status = STATUS_OK;
      case (cmd)
         CMD_ADD_USABLE: begin
            if (region_cnt >= REGION_SLOTS) g.status = STATUS_FULL;
            else begin
               region_lo[region_cnt] = rs;
               region_hi[region_cnt] = re;
               region_cnt++;
            end
         end
         CMD_ADD_KERNEL: begin
            if (kern_cnt >= KERNEL_SLOTS) g.status = STATUS_FULL;
            else begin
               kern_lo[kern_cnt] = rs;
               kern_hi[kern_cnt] = re;
               kern_cnt++;
            end
         end
         CMD_ALLOCATE: begin
            got = 0;
            if (!exhausted) begin
               if (next_scan_frame(f)) begin
                  cursor = f;
                  g.frame_address = ADDRESS_BITS'(f << OFFSET_BITS);
                  got = 1;
               end else begin
                  exhausted = 1;
               end
            end
            if (!got) begin
               if (returned_frames.size() > 0) begin
                  g.frame_address = ADDRESS_BITS'(returned_frames.pop_front() << OFFSET_BITS);
               end else begin
                  g.status = STATUS_EMPTY;
               end
            end
         end
         default: begin
            if (fa[OFFSET_BITS-1:0] != 0) g.status = STATUS_MISALIGNED;
            else if (returned_frames.size() >= FREE_QUEUE_DEPTH) g.status = STATUS_FULL;
            else returned_frames.push_back(fa >> OFFSET_BITS);
         end
      endcase
      return g;
   endfunction

   assign pending = grants.size();

   always @(posedge clock) begin
      grant_type want;
      if (reset) begin
         grants.delete();
         returned_frames.delete();
         region_cnt = 0;
         kern_cnt = 0;
         cursor = 0;
         exhausted = 0;
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (grants.size() == 0) begin
               $display("%0t: unexpected response address %h status %0d", $time,
                        rsp_frame_address, rsp_status);
               fail_count++;
            end else begin
               want = grants.pop_front();
               if (rsp_frame_address !== want.frame_address) begin
                  $display("%0t: frame_address expected %h actual %h", $time,
                           want.frame_address, rsp_frame_address);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, want.status,
                           rsp_status);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            grants.push_back(serve_request(req_command, 64'(req_region_start),
                                           64'(req_region_end), 64'(req_free_address)));
      end
   end

endmodule

// ===== verif/tb_physical_frame_allocator.sv =====
// Testbench top for the physical frame allocator: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps
module tb_physical_frame_allocator import pfa_pkg::*;;

   localparam int PLANNED   = 1167;
   localparam int MAX_CYCLE = 3000000;
   localparam logic [ADDRESS_BITS-1:0] TOP_ADDR = '1;

   logic                    clock = 0;
   logic                    reset = 1;
   logic                    req_valid = 0;
   logic                    req_stall;
   logic [1:0]              req_command = CMD_ALLOCATE;
   logic [ADDRESS_BITS-1:0] req_region_start = '0;
   logic [ADDRESS_BITS-1:0] req_region_end = '0;
   logic [ADDRESS_BITS-1:0] req_free_address = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 0;
   logic [ADDRESS_BITS-1:0] rsp_frame_address;
   logic [1:0]              rsp_status;
   int                      fail_count;
   int                      pending;
   int                      sent = 0;
   int                      cycles = 0;
   int                      usable_sent = 0;
   int                      kernel_sent = 0;

   always #10 clock = ~clock;

   physical_frame_allocator u_top (
      .clock, .reset, .req_valid, .req_stall, .req_command, .req_region_start,
      .req_region_end, .req_free_address, .rsp_valid, .rsp_stall, .rsp_frame_address,
      .rsp_status
   );

   pfa_checker u_checker (
      .clock, .reset, .req_valid, .req_stall, .req_command, .req_region_start,
      .req_region_end, .req_free_address, .rsp_valid, .rsp_stall, .rsp_frame_address,
      .rsp_status, .fail_count, .pending
   );

   function automatic int sender_idle_pct();
      if (sent < PLANNED / 3) return 19;
      if (sent < 2 * PLANNED / 3) return 77;
      return 0;
   endfunction

   function automatic int receiver_idle_pct();
      if (sent < PLANNED / 3) return 77;
      if (sent < 2 * PLANNED / 3) return 19;
      return 0;
   endfunction

   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < receiver_idle_pct());
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > MAX_CYCLE) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send(input logic [1:0] cmd, input logic [ADDRESS_BITS-1:0] rs,
                       input logic [ADDRESS_BITS-1:0] re, input logic [ADDRESS_BITS-1:0] fa);
      while ($urandom_range(99) < sender_idle_pct()) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_command = cmd;
      req_region_start = rs;
      req_region_end = re;
      req_free_address = fa;
      req_valid = 1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
      @(negedge clock);
   endtask

   function automatic logic [ADDRESS_BITS-1:0] frame_addr(input longint unsigned f);
      return ADDRESS_BITS'(f << OFFSET_BITS);
   endfunction

   function automatic logic [ADDRESS_BITS-1:0] random_addr();
      return ADDRESS_BITS'({$urandom(), $urandom()});
   endfunction

   task automatic send_low_region(input logic [1:0] cmd);
      longint unsigned f;
      logic [ADDRESS_BITS-1:0] lo;
      logic [ADDRESS_BITS-1:0] hi;
      f = 64'($urandom_range(200, 1));
      lo = frame_addr(f);
      hi = frame_addr(f + 64'($urandom_range(8, 1)));
      if ($urandom_range(3) == 0) lo = lo + ADDRESS_BITS'($urandom_range(4095, 1));
      if ($urandom_range(3) == 0) hi = hi + ADDRESS_BITS'($urandom_range(4095, 1));
      send(cmd, lo, hi, random_addr());
   endtask

   task automatic send_free();
      logic [ADDRESS_BITS-1:0] a;
      a = random_addr();
      if ($urandom_range(4) != 0) a[OFFSET_BITS-1:0] = '0;
      send(CMD_FREE, random_addr(), random_addr(), a);
   endtask

   initial begin
      int pick;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      send(CMD_ADD_USABLE, 48'h1000, 48'h9000, '0);
      send(CMD_ADD_USABLE, TOP_ADDR, '0, TOP_ADDR);
      send(CMD_ADD_USABLE, 48'h5000, 48'h5000, '0);
      send(CMD_ADD_USABLE, 48'h10800, 48'h20000, '0);
      send(CMD_ADD_USABLE, TOP_ADDR - 48'h1fff, TOP_ADDR, '0);
      send(CMD_ADD_KERNEL, 48'h3000, 48'h3001, '0);
      send(CMD_ADD_KERNEL, 48'h18000, 48'h1a000, '0);
      repeat (3) send(CMD_ALLOCATE, '0, '0, '0);
      send(CMD_FREE, '0, '0, TOP_ADDR);
      send(CMD_FREE, '0, '0, '0);
      send(CMD_FREE, '0, '0, 48'h5000);
      send(CMD_FREE, '0, '0, 48'h5000);
      send(CMD_FREE, '0, '0, TOP_ADDR - 48'hfff);
      repeat (2) send(CMD_ALLOCATE, '0, '0, '0);
      usable_sent = 5;
      kernel_sent = 2;

      repeat (350) begin
         pick = $urandom_range(99);
         if (pick < 15 && usable_sent < 40) begin
            send_low_region(CMD_ADD_USABLE);
            usable_sent++;
         end else if (pick < 25 && kernel_sent < 30) begin
            send_low_region(CMD_ADD_KERNEL);
            kernel_sent++;
         end else if (pick < 70) begin
            send(CMD_ALLOCATE, random_addr(), random_addr(), random_addr());
         end else begin
            send_free();
         end
      end

      repeat (250) send(CMD_ALLOCATE, random_addr(), random_addr(), random_addr());

      repeat (250) begin
         pick = $urandom_range(99);
         if (pick < 45) send(CMD_ADD_USABLE, random_addr(), random_addr(), random_addr());
         else if (pick < 90) send(CMD_ADD_KERNEL, random_addr(), random_addr(), random_addr());
         else if (pick < 95) send(CMD_ALLOCATE, random_addr(), random_addr(), random_addr());
         else send_free();
      end

      repeat (300) begin
         if ($urandom_range(99) < 3) send(CMD_ALLOCATE, '0, '0, '0);
         else send_free();
      end
      req_valid = 0;

      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/pfa_pkg.sv
rtl/pfa_ctrl.sv
rtl/pfa_dp.sv
rtl/physical_frame_allocator.sv
verif/pfa_checker.sv
verif/tb_physical_frame_allocator.sv
